### hdl/cpa_pkg.sv
// Package for the complex pair ALU: opcodes, widths, stage records and
// the saturate, divide-step and root-step helpers. No dependencies.
`default_nettype none
package cpa_pkg;

  localparam int DW     = 32;        // data width, signed
  localparam int FB     = 16;        // fraction bits
  localparam int TOL_W  = DW - 1;    // tolerance register width
  localparam int PW     = 2 * DW;    // full product width
  localparam int SW     = PW + 2;    // sum width with headroom
  localparam int QB     = DW + 1;    // quotient bits produced by the divider
  localparam int NIT    = QB;        // iterative stages (divide and root)
  localparam int SRT    = DW;        // root steps
  localparam int RW     = DW + 2;    // root remainder width

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_CMUL  = 4'd4;
  localparam logic [3:0] OP_CDIV  = 4'd5;
  localparam logic [3:0] OP_ROTJ  = 4'd6;
  localparam logic [3:0] OP_DOT   = 4'd7;
  localparam logic [3:0] OP_NORM  = 4'd8;
  localparam logic [3:0] OP_CWMUL = 4'd9;
  localparam logic [3:0] OP_EQ    = 4'd10;
  localparam logic [3:0] OP_NE    = 4'd11;

  localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd1 <<< (DW - 1));

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } sat_t;

  // products and early results
  typedef struct packed {
    logic [3:0]            op;
    logic signed [PW-1:0]  m0, m1, m2, m3, m4, m5;
    logic [DW-1:0]         re, im;
    logic                  cmp, sat;
  } s1_t;

  // record carried through the divide / root stages
  typedef struct packed {
    logic [3:0]    op;
    logic [DW-1:0] re, im, sc;
    logic          cmp, dz, sat;
    logic          neg_re, neg_im, ovf_re, ovf_im;
    logic [PW-1:0] nre, nim, den;
    logic [PW-1:0] rem_re, rem_im;
    logic [QB-1:0] q_re, q_im;
    logic [PW-1:0] sx;
    logic [RW-1:0] srem;
    logic [DW-1:0] root;
  } it_t;

  typedef struct packed {
    logic          q;
    logic [PW-1:0] rem;
  } div_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] root;
  } sqrt_t;

  function automatic sat_t sat_clip(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = SAT_MAX[DW-1:0];
    end else if (v < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = SAT_MIN[DW-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic div_t div_step(input logic [PW-1:0] rem, input logic nb,
                                    input logic [PW-1:0] den);
    logic [PW:0] t;
    div_t r;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      r.q   = 1'b1;
      r.rem = PW'(t - {1'b0, den});
    end else begin
      r.q   = 1'b0;
      r.rem = t[PW-1:0];
    end
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(input logic [RW-1:0] rem, input logic [DW-1:0] root,
                                      input logic [1:0] pair);
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    sqrt_t r;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      r.rem  = RW'(t - trial);
      r.root = {root[DW-2:0], 1'b1};
    end else begin
      r.rem  = t[RW-1:0];
      r.root = {root[DW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/cpa_in_if.sv
// Request channel of the complex pair ALU: valid/ready plus operands.
// Depends on cpa_pkg.
`default_nettype none
interface cpa_in_if import cpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [3:0]           opcode;
  logic signed [DW-1:0] a_re, a_im, b_re, b_im, scalar;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, scalar, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, scalar, output ready);
endinterface
`default_nettype wire

### hdl/cpa_out_if.sv
// Result channel of the complex pair ALU: valid/ready plus results and flags.
// Depends on cpa_pkg.
`default_nettype none
interface cpa_out_if import cpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_re, res_im, res_scalar;
  logic                 compare_true, divide_by_zero, saturated;

  modport source (output valid, res_re, res_im, res_scalar, compare_true, divide_by_zero,
                  saturated, input ready);
  modport sink   (input valid, res_re, res_im, res_scalar, compare_true, divide_by_zero,
                  saturated, output ready);
endinterface
`default_nettype wire

### hdl/complex_pair_alu.sv
// Complex pair ALU top level: Q16.16 pair / complex arithmetic, pipelined.
// Depends on cpa_pkg, cpa_in_if, cpa_out_if.
//
// Usage:
// - in_ch carries one request: opcode, pairs a and b, and a scalar.
//   A request is taken on a clock edge with valid and ready both high.
// - out_ch returns exactly one result per request, in request order:
//   pair, scalar, compare bit, and the divide-by-zero / saturated flags.
// - cfg_we / cfg_wdata write the equality tolerance (reset value 1).
//   Write it only while no request is in flight.
// - The latency from the accepting edge to out_ch.valid is the same for
//   every opcode. Throughput: one request per cycle while out_ch is not stalled.
// - Depth is set by the divider, one quotient bit per stage over 33
//   stages (the square root rides in all but the last of them, two radicand bits a step),
//   plus a multiply stage and a sum stage in front.
// - The whole pipe advances together: when out_ch holds a result that is
//   not taken, every stage freezes and in_ch.ready drops; nothing is lost
//   or repeated. Bubbles travel as cleared valid bits.
// - Reset (rst_n low, synchronous) empties the pipe and restores the
//   tolerance; payload registers are not cleared.
`default_nettype none
module complex_pair_alu import cpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cpa_in_if.sink           in_ch,
  cpa_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  logic [TOL_W-1:0] tol_r;

  // global advance: the pipe moves whenever the output slot is free or taken
  logic adv;

  s1_t  s1_r, s1_nxt;
  logic s1_valid_r;

  it_t  it_r     [0:NIT-1];
  it_t  step_nxt [0:NIT-1];
  it_t  it0_nxt;
  logic [NIT-1:0] itv_r;

  logic                 out_valid_r;
  logic signed [DW-1:0] res_re_r, res_im_r, res_sc_r, res_re_nxt, res_im_nxt, res_sc_nxt;
  logic                 cmp_r, dz_r, sat_r, cmp_nxt, dz_nxt, sat_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // ---------------- stage 1: multipliers and the simple ops ----------------
  always_comb begin
    logic signed [DW-1:0] x0, x1;
    logic signed [DW:0]   dre, dim;
    logic [DW:0]          are, aim;
    sat_t                 cr, ci;
    s1_nxt    = '0;
    s1_nxt.op = in_ch.opcode;
    x0 = in_ch.b_re;
    x1 = in_ch.b_im;
    if (in_ch.opcode == OP_SCALE) begin
      x0 = in_ch.scalar;
      x1 = in_ch.scalar;
    end else if (in_ch.opcode == OP_NORM) begin
      x0 = in_ch.a_re;
      x1 = in_ch.a_im;
    end
    s1_nxt.m0 = PW'(in_ch.a_re) * PW'(x0);
    s1_nxt.m1 = PW'(in_ch.a_im) * PW'(x1);
    s1_nxt.m2 = PW'(in_ch.a_re) * PW'(in_ch.b_im);
    s1_nxt.m3 = PW'(in_ch.a_im) * PW'(in_ch.b_re);
    s1_nxt.m4 = PW'(in_ch.b_re) * PW'(in_ch.b_re);
    s1_nxt.m5 = PW'(in_ch.b_im) * PW'(in_ch.b_im);

    dre = (DW+1)'(in_ch.a_re) - (DW+1)'(in_ch.b_re);
    dim = (DW+1)'(in_ch.a_im) - (DW+1)'(in_ch.b_im);
    are = dre[DW] ? $unsigned(-dre) : $unsigned(dre);
    aim = dim[DW] ? $unsigned(-dim) : $unsigned(dim);
    cr  = '0;
    ci  = '0;
    unique case (in_ch.opcode)
      OP_ADD: begin
        cr = sat_clip(SW'(in_ch.a_re) + SW'(in_ch.b_re));
        ci = sat_clip(SW'(in_ch.a_im) + SW'(in_ch.b_im));
      end
      OP_SUB: begin
        cr = sat_clip(SW'(dre));
        ci = sat_clip(SW'(dim));
      end
      OP_NEG: begin
        cr = sat_clip(-SW'(in_ch.a_re));
        ci = sat_clip(-SW'(in_ch.a_im));
      end
      OP_ROTJ: begin
        cr = sat_clip(-SW'(in_ch.a_im));
        ci = sat_clip(SW'(in_ch.a_re));
      end
      OP_EQ: s1_nxt.cmp = (are < {2'b00, tol_r}) && (aim < {2'b00, tol_r});
      OP_NE: s1_nxt.cmp = !((are < {2'b00, tol_r}) && (aim < {2'b00, tol_r}));
      default: ;
    endcase
    s1_nxt.re  = cr.val;
    s1_nxt.im  = ci.val;
    s1_nxt.sat = cr.sat || ci.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- stage 2: sums, rescale, divider / root setup ----------------
  always_comb begin
    logic signed [SW-1:0] e0, e1, e2, e3, nr, ni;
    logic [SW-1:0]        ar, ai;
    sat_t                 cr, ci;
    e0 = SW'(s1_r.m0);
    e1 = SW'(s1_r.m1);
    e2 = SW'(s1_r.m2);
    e3 = SW'(s1_r.m3);
    nr = e0 + e1;
    ni = e3 - e2;
    ar = nr[SW-1] ? $unsigned(-nr) : $unsigned(nr);
    ai = ni[SW-1] ? $unsigned(-ni) : $unsigned(ni);
    cr = '0;
    ci = '0;

    it0_nxt        = '0;
    it0_nxt.op     = s1_r.op;
    it0_nxt.re     = s1_r.re;
    it0_nxt.im     = s1_r.im;
    it0_nxt.cmp    = s1_r.cmp;
    it0_nxt.sat    = s1_r.sat;
    it0_nxt.nre    = ar[PW-1:0];
    it0_nxt.nim    = ai[PW-1:0];
    it0_nxt.neg_re = nr[SW-1];
    it0_nxt.neg_im = ni[SW-1];
    it0_nxt.den    = PW'($unsigned(s1_r.m4) + $unsigned(s1_r.m5));
    it0_nxt.sx     = nr[PW-1:0];
    // remainder starts with the numerator bits above the quotient window
    it0_nxt.rem_re = PW'(ar[PW-1:FB+1]);
    it0_nxt.rem_im = PW'(ai[PW-1:FB+1]);
    it0_nxt.ovf_re = PW'(ar[PW-1:FB+1]) >= it0_nxt.den;
    it0_nxt.ovf_im = PW'(ai[PW-1:FB+1]) >= it0_nxt.den;

    unique case (s1_r.op)
      OP_SCALE, OP_CWMUL: begin
        cr = sat_clip(e0 >>> FB);
        ci = sat_clip(e1 >>> FB);
        it0_nxt.re  = cr.val;
        it0_nxt.im  = ci.val;
        it0_nxt.sat = cr.sat || ci.sat;
      end
      OP_CMUL: begin
        cr = sat_clip((e0 - e1) >>> FB);
        ci = sat_clip((e2 + e3) >>> FB);
        it0_nxt.re  = cr.val;
        it0_nxt.im  = ci.val;
        it0_nxt.sat = cr.sat || ci.sat;
      end
      OP_DOT: begin
        cr = sat_clip(nr >>> FB);
        it0_nxt.sc  = cr.val;
        it0_nxt.sat = cr.sat;
      end
      OP_CDIV: it0_nxt.dz = (it0_nxt.den == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itv_r <= '0;
    end else if (adv) begin
      itv_r <= {itv_r[NIT-2:0], s1_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= it0_nxt;
    end
  end

  // iterative stages: one quotient bit each, one root bit in all but the last
  for (genvar k = 0; k < NIT; k++) begin : g_step
    localparam int J = QB - 1 - k;  // quotient bit made here
    logic nb_re, nb_im;
    if (J >= FB) begin : g_nb
      assign nb_re = it_r[k].nre[J-FB];
      assign nb_im = it_r[k].nim[J-FB];
    end else begin : g_zero
      assign nb_re = 1'b0;
      assign nb_im = 1'b0;
    end

    always_comb begin
      div_t dr, di;
      step_nxt[k]      = it_r[k];
      dr               = div_step(it_r[k].rem_re, nb_re, it_r[k].den);
      di               = div_step(it_r[k].rem_im, nb_im, it_r[k].den);
      step_nxt[k].rem_re = dr.rem;
      step_nxt[k].rem_im = di.rem;
      step_nxt[k].q_re   = {it_r[k].q_re[QB-2:0], dr.q};
      step_nxt[k].q_im   = {it_r[k].q_im[QB-2:0], di.q};
    end

    if (k < SRT) begin : g_root
      sqrt_t sr;
      it_t   stage_nxt;
      assign sr = sqrt_step(it_r[k].srem, it_r[k].root, it_r[k].sx[PW-1-2*k -: 2]);
      always_comb begin
        stage_nxt      = step_nxt[k];
        stage_nxt.srem = sr.rem;
        stage_nxt.root = sr.root;
      end
      always_ff @(posedge clk) begin
        if (adv && k < NIT - 1) begin
          it_r[k+1] <= stage_nxt;
        end
      end
    end
  end

  // ---------------- output stage: divide / root wrap-up ----------------
  always_comb begin
    it_t           l;
    logic [QB:0]   mr, mi;
    res_re_nxt = '0;
    res_im_nxt = '0;
    res_sc_nxt = '0;
    l          = step_nxt[NIT-1];
    cmp_nxt    = l.cmp;
    dz_nxt     = 1'b0;
    sat_nxt    = l.sat;
    mr = {1'b0, l.q_re} + (QB+1)'(l.neg_re && (l.rem_re != '0));
    mi = {1'b0, l.q_im} + (QB+1)'(l.neg_im && (l.rem_im != '0));
    unique case (l.op)
      OP_ADD, OP_SUB, OP_NEG, OP_ROTJ, OP_SCALE, OP_CMUL, OP_CWMUL: begin
        res_re_nxt = l.re;
        res_im_nxt = l.im;
      end
      OP_DOT: res_sc_nxt = l.sc;
      OP_NORM: begin
        // root of a sum of squares of two signed values can pass the max
        if (l.root[DW-1]) begin
          res_sc_nxt = SAT_MAX[DW-1:0];
          sat_nxt    = 1'b1;
        end else begin
          res_sc_nxt = l.root;
        end
      end
      OP_CDIV: begin
        if (l.dz) begin
          dz_nxt = 1'b1;
        end else begin
          if (l.ovf_re || (l.neg_re ? (mr > (QB+1)'(1) << (DW-1))
                                    : (mr > ((QB+1)'(1) << (DW-1)) - (QB+1)'(1)))) begin
            sat_nxt    = 1'b1;
            res_re_nxt = l.neg_re ? SAT_MIN[DW-1:0] : SAT_MAX[DW-1:0];
          end else begin
            res_re_nxt = l.neg_re ? -mr[DW-1:0] : mr[DW-1:0];
          end
          if (l.ovf_im || (l.neg_im ? (mi > (QB+1)'(1) << (DW-1))
                                    : (mi > ((QB+1)'(1) << (DW-1)) - (QB+1)'(1)))) begin
            sat_nxt    = 1'b1;
            res_im_nxt = l.neg_im ? SAT_MIN[DW-1:0] : SAT_MAX[DW-1:0];
          end else begin
            res_im_nxt = l.neg_im ? -mi[DW-1:0] : mi[DW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= itv_r[NIT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      res_sc_r <= res_sc_nxt;
      cmp_r    <= cmp_nxt;
      dz_r     <= dz_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_re         = res_re_r;
  assign out_ch.res_im         = res_im_r;
  assign out_ch.res_scalar     = res_sc_r;
  assign out_ch.compare_true   = cmp_r;
  assign out_ch.divide_by_zero = dz_r;
  assign out_ch.saturated      = sat_r;

  // ---------------- checks ----------------
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> res_re_r == '0 && res_im_r == '0 && !sat_r)
    else $error("divide by zero result not cleared");

  a_cmp_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cmp_r |-> res_re_r == '0 && res_im_r == '0 && res_sc_r == '0)
    else $error("compare result with nonzero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(itv_r) && $stable(s1_valid_r))
    else $error("pipe moved during a stall");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && itv_r[NIT-1] |=> out_valid_r)
    else $error("result dropped at output stage");

endmodule
`default_nettype wire
